// ----- src/ncpth_pkg.sv -----
// shared constants for the navigation cell point test block
`default_nettype none

package ncpth_pkg;

    localparam int CFG_DATA_WIDTH  = 60;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int NBR_WIDTH       = 16;
    localparam int NBR_REG_WIDTH   = 3 * NBR_WIDTH;
    localparam int NUM_EDGES       = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_VERTEX_A  = 2'd0,
        REG_VERTEX_B  = 2'd1,
        REG_VERTEX_C  = 2'd2,
        REG_NEIGHBORS = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/nav_cell_point_test_height.sv -----
// navigation cell point test: edge tests, plane height and pipelined divider
//
// Usage: load the triangle through the write port (wr_en, wr_index, wr_data)
// while no query is in flight, then stream queries. The input channel
// (in_valid, in_stall, pos_x, pos_z) takes one word per cycle while in_stall is low; the output
// channel (out_valid, out_stall, inside_res, exit_neighbor, height,
// height_valid) returns exactly one word per query, in order.
// Throughput is one word per cycle while the pipeline is not held; the
// depth comes from the restoring divider for the plane height, which
// resolves one quotient bit per stage after a saturation check stage.
// Queries may be sent after the last configuration write.
// Reset clears all stage valid bits and loads the triangle registers with
// zero vertices and no neighbors (-1 on every edge).
// When out_stall is high while a word is waiting, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated. Bubbles move on while
// the output stage is empty.
`default_nettype none

module nav_cell_point_test_height #(
    parameter int COORD_WIDTH = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [ncpth_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  wire logic [ncpth_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]         pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]         pos_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       inside_res,
    output logic signed [ncpth_pkg::NBR_WIDTH-1:0]     exit_neighbor,
    output logic signed [COORD_WIDTH-1:0]              height,
    output logic                                       height_valid
);
    import ncpth_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;           // coordinate difference
    localparam int PW  = 2 * W + 3;       // normal component, edge product
    localparam int SW  = 2 * W + 4;       // edge dot product
    localparam int MW  = 3 * W + 4;       // height product
    localparam int NW  = 3 * W + 5;       // height numerator
    localparam int QW  = W + 2;           // signed quotient and sum

    // configuration registers
    logic [CFG_DATA_WIDTH-1:0] vtx_reg [NUM_EDGES];
    logic [NBR_REG_WIDTH-1:0]  nbr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg[0] <= '0;
            vtx_reg[1] <= '0;
            vtx_reg[2] <= '0;
            nbr_reg    <= '1;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_VERTEX_A:  vtx_reg[0] <= wr_data;
                REG_VERTEX_B:  vtx_reg[1] <= wr_data;
                REG_VERTEX_C:  vtx_reg[2] <= wr_data;
                REG_NEIGHBORS: nbr_reg    <= wr_data[NBR_REG_WIDTH-1:0];
                default:       nbr_reg    <= nbr_reg;
            endcase
        end
    end

    // vertex fields past the register width read as zero
    logic [3*W-1:0]      vtx_fit [NUM_EDGES];
    logic signed [W-1:0] vx [NUM_EDGES];
    logic signed [W-1:0] vy [NUM_EDGES];
    logic signed [W-1:0] vz [NUM_EDGES];

    always_comb
    begin
        for (int v = 0; v < NUM_EDGES; v++)
        begin
            vtx_fit[v] = (3*W)'(vtx_reg[v]);
            vx[v] = signed'(vtx_fit[v][0 +: W]);
            vy[v] = signed'(vtx_fit[v][W +: W]);
            vz[v] = signed'(vtx_fit[v][2*W +: W]);
        end
    end

    // derived triangle terms, registered after a write: differences, then normal, then divisor and ny flags
    logic signed [DW-1:0] ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [DW-1:0] edx_reg [NUM_EDGES];
    logic signed [DW:0]   endz_reg [NUM_EDGES];
    logic signed [PW-1:0] nx_reg, ny_reg, nz_reg;
    logic [PW-1:0]        den_reg;
    logic                 ny_neg_reg, ny_zero_reg;

    always_ff @(posedge clk)
    begin
        ux_reg <= DW'(vx[0]) - DW'(vx[1]);
        uy_reg <= DW'(vy[0]) - DW'(vy[1]);
        uz_reg <= DW'(vz[0]) - DW'(vz[1]);
        wx_reg <= DW'(vx[0]) - DW'(vx[2]);
        wy_reg <= DW'(vy[0]) - DW'(vy[2]);
        wz_reg <= DW'(vz[0]) - DW'(vz[2]);
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            edx_reg[e]  <= DW'(vx[(e + 1) % NUM_EDGES]) - DW'(vx[e]);
            endz_reg[e] <= (DW + 1)'(vz[e]) - (DW + 1)'(vz[(e + 1) % NUM_EDGES]);
        end
        nx_reg <= PW'(uy_reg * wz_reg) - PW'(uz_reg * wy_reg);
        ny_reg <= PW'(uz_reg * wx_reg) - PW'(ux_reg * wz_reg);
        nz_reg <= PW'(ux_reg * wy_reg) - PW'(uy_reg * wx_reg);
        den_reg     <= ny_reg[PW-1] ? PW'(-ny_reg) : PW'(ny_reg);
        ny_neg_reg  <= ny_reg[PW-1];
        ny_zero_reg <= (ny_reg == '0);
    end

    // pipeline control: everything moves unless a finished word is held
    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // stage 1: capture query
    logic              v1_reg;
    logic signed [W-1:0] px1_reg, pz1_reg;

    // stage 2: differences
    logic              v2_reg;
    logic signed [DW-1:0] ex2_reg [NUM_EDGES];
    logic signed [DW-1:0] ez2_reg [NUM_EDGES];
    logic signed [DW-1:0] hx2_reg, hz2_reg;

    // stage 3: products
    logic              v3_reg;
    logic signed [PW-1:0] pa3_reg [NUM_EDGES];
    logic signed [PW-1:0] pb3_reg [NUM_EDGES];
    logic signed [MW-1:0] hxp3_reg, hzp3_reg;

    // stage 4: edge verdict and numerator magnitude
    logic              v4_reg;
    logic              in4_reg;
    logic [NBR_WIDTH-1:0] nb4_reg;
    logic [NW-1:0]     mag4_reg;
    logic              neg4_reg;

    logic signed [SW-1:0] dot [NUM_EDGES];
    logic signed [NW-1:0] num;
    logic                 in4_next;
    logic [NBR_WIDTH-1:0] nb4_next;

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            dot[e] = SW'(pa3_reg[e]) + SW'(pb3_reg[e]);
        end
        num      = NW'(hxp3_reg) + NW'(hzp3_reg);
        in4_next = 1'b1;
        nb4_next = '1;
        priority if (!dot[0][SW-1] && dot[0] != '0)
        begin
            in4_next = 1'b0;
            nb4_next = nbr_reg[0 +: NBR_WIDTH];
        end
        else if (!dot[1][SW-1] && dot[1] != '0)
        begin
            in4_next = 1'b0;
            nb4_next = nbr_reg[NBR_WIDTH +: NBR_WIDTH];
        end
        else if (!dot[2][SW-1] && dot[2] != '0)
        begin
            in4_next = 1'b0;
            nb4_next = nbr_reg[2*NBR_WIDTH +: NBR_WIDTH];
        end
        else
        begin
            in4_next = 1'b1;
            nb4_next = '1;
        end
    end

    // divider stages: index 0 checks saturation, index j resolves bit W-j
    logic                 dv_reg  [W+1];
    logic                 din_reg [W+1];
    logic [NBR_WIDTH-1:0] dnb_reg [W+1];
    logic [NW-1:0]        drem_reg [W+1];
    logic [W-1:0]         dquo_reg [W+1];
    logic                 dovf_reg [W+1];
    logic                 dneg_reg [W+1];

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= W; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int j = 1; j <= W; j++)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
            out_valid_reg <= dv_reg[W];
        end
    end

    logic [NW-1:0] dsub [W+1];

    always_comb
    begin
        for (int j = 0; j <= W; j++)
        begin
            dsub[j] = NW'(den_reg) << (W - j);
        end
    end

    logic signed [QW-1:0] q_mag;
    logic signed [QW-1:0] q_sgn;
    logic signed [QW-1:0] h_sum;
    logic signed [QW-1:0] h_max;
    logic signed [QW-1:0] h_min;
    logic signed [W-1:0]  h_sat;

    always_comb
    begin
        q_mag = dovf_reg[W] ? (QW'(1) << W) : QW'(dquo_reg[W]);
        q_sgn = dneg_reg[W] ? -q_mag : q_mag;
        h_sum = QW'(vy[0]) + q_sgn;
        h_max = QW'({1'b0, {(W-1){1'b1}}});
        h_min = -h_max - QW'(1);
        priority if (h_sum > h_max)
        begin
            h_sat = h_max[W-1:0];
        end
        else if (h_sum < h_min)
        begin
            h_sat = h_min[W-1:0];
        end
        else
        begin
            h_sat = h_sum[W-1:0];
        end
    end

    logic                  res_in_reg;
    logic [NBR_WIDTH-1:0]  res_nb_reg;
    logic signed [W-1:0]   res_h_reg;
    logic                  res_hv_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px1_reg <= pos_x;
            pz1_reg <= pos_z;

            for (int e = 0; e < NUM_EDGES; e++)
            begin
                ex2_reg[e] <= DW'(px1_reg) - DW'(vx[e]);
                ez2_reg[e] <= DW'(pz1_reg) - DW'(vz[e]);
            end
            hx2_reg <= DW'(vx[0]) - DW'(px1_reg);
            hz2_reg <= DW'(vz[0]) - DW'(pz1_reg);

            for (int e = 0; e < NUM_EDGES; e++)
            begin
                pa3_reg[e] <= PW'(ex2_reg[e] * endz_reg[e]);
                pb3_reg[e] <= PW'(ez2_reg[e] * edx_reg[e]);
            end
            hxp3_reg <= MW'(nx_reg * hx2_reg);
            hzp3_reg <= MW'(nz_reg * hz2_reg);

            in4_reg  <= in4_next;
            nb4_reg  <= nb4_next;
            neg4_reg <= num[NW-1];
            mag4_reg <= num[NW-1] ? NW'(-num) : NW'(num);

            // saturation check: quotient would reach 2^W
            din_reg[0]  <= in4_reg;
            dnb_reg[0]  <= nb4_reg;
            drem_reg[0] <= mag4_reg;
            dquo_reg[0] <= '0;
            dovf_reg[0] <= (mag4_reg >= dsub[0]);
            dneg_reg[0] <= neg4_reg ^ ny_neg_reg;

            for (int j = 1; j <= W; j++)
            begin
                din_reg[j]  <= din_reg[j-1];
                dnb_reg[j]  <= dnb_reg[j-1];
                dovf_reg[j] <= dovf_reg[j-1];
                dneg_reg[j] <= dneg_reg[j-1];
                if (drem_reg[j-1] >= dsub[j])
                begin
                    drem_reg[j] <= drem_reg[j-1] - dsub[j];
                    dquo_reg[j] <= dquo_reg[j-1] | (W'(1) << (W - j));
                end
                else
                begin
                    drem_reg[j] <= drem_reg[j-1];
                    dquo_reg[j] <= dquo_reg[j-1];
                end
            end

            res_in_reg <= din_reg[W];
            res_nb_reg <= dnb_reg[W];
            res_hv_reg <= !ny_zero_reg;
            res_h_reg  <= ny_zero_reg ? '0 : h_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign inside_res    = res_in_reg;
    assign exit_neighbor = signed'(res_nb_reg);
    assign height        = res_h_reg;
    assign height_valid  = res_hv_reg;

endmodule

`default_nettype wire

// ----- tb/tb_nav_cell_point_test_height.sv -----
// self-checking testbench for the navigation cell point test with plane height
`default_nettype none

module tb_nav_cell_point_test_height;
    import ncpth_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 20;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] z;
    } query_t;

    typedef struct {
        logic                 in_cell;
        logic signed [15:0]   nbr;
        logic signed [CW-1:0] hgt;
        logic                 hvalid;
    } cell_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] wr_index = '0;
    logic [CFG_DATA_WIDTH-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] pos_x = '0;
    logic signed [CW-1:0] pos_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic inside_res;
    logic signed [15:0] exit_neighbor;
    logic signed [CW-1:0] height;
    logic height_valid;

    // triangle as the testbench believes it is loaded
    longint vx [3], vy [3], vz [3];
    logic [47:0] nbr_reg;

    query_t pending_q [$];
    cell_hit_t hit_q [$];
    int errors = 0;
    int sent = 0;
    int recvd = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    nav_cell_point_test_height #(.COORD_WIDTH(CW)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cell_hit_t locate_point(query_t q);
        cell_hit_t r;
        longint px, pz, sx, sz, dx, dz, dot, nx, ny, nz, h;
        logic signed [127:0] num, quo;
        px = q.x;
        pz = q.z;
        r.in_cell = 1'b1;
        r.nbr = -16'sd1;
        r.hgt = '0;
        r.hvalid = 1'b0;
        for (int e = 0; e < 3; e++)
        begin
            sx = vx[e];
            sz = vz[e];
            dx = vx[(e + 1) % 3] - sx;
            dz = vz[(e + 1) % 3] - sz;
            dot = (px - sx) * (-dz) + (pz - sz) * dx;
            if (r.in_cell && dot > 0)
            begin
                r.in_cell = 1'b0;
                r.nbr = nbr_reg[16*e +: 16];
            end
        end
        nx = (vy[0] - vy[1]) * (vz[0] - vz[2]) - (vz[0] - vz[1]) * (vy[0] - vy[2]);
        ny = (vz[0] - vz[1]) * (vx[0] - vx[2]) - (vx[0] - vx[1]) * (vz[0] - vz[2]);
        nz = (vx[0] - vx[1]) * (vy[0] - vy[2]) - (vy[0] - vy[1]) * (vx[0] - vx[2]);
        if (ny != 0)
        begin
            num = 128'(nx) * 128'(vx[0] - px) + 128'(nz) * 128'(vz[0] - pz);
            quo = num / 128'(ny);
            // quotient saturates far before it leaves a longint once clamped
            if (quo > 128'sd1000000000)
                h = CMAX;
            else if (quo < -128'sd1000000000)
                h = CMIN;
            else
                h = vy[0] + longint'(quo);
            if (h > CMAX)
                h = CMAX;
            if (h < CMIN)
                h = CMIN;
            r.hgt = h[CW-1:0];
            r.hvalid = 1'b1;
        end
        return r;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                hit_q.push_back(locate_point('{x: pos_x, z: pos_z}));
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 &&
                    (($urandom_range(99) >= 29) || (sent > 150 && sent < 320)))
                begin
                    query_t q;
                    q = pending_q.pop_front();
                    in_valid <= 1'b1;
                    pos_x <= q.x;
                    pos_z <= q.z;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (hit_q.size() == 0)
                begin
                    $display("%0t: unexpected word inside=%0b nbr=%0d height=%0d hv=%0b",
                             $time, inside_res, exit_neighbor, height, height_valid);
                    errors++;
                end
                else
                begin
                    cell_hit_t e;
                    e = hit_q.pop_front();
                    if (inside_res !== e.in_cell)
                    begin
                        $display("%0t: inside_res expected %0b actual %0b",
                                 $time, e.in_cell, inside_res);
                        errors++;
                    end
                    if (exit_neighbor !== e.nbr)
                    begin
                        $display("%0t: exit_neighbor expected %0d actual %0d",
                                 $time, e.nbr, exit_neighbor);
                        errors++;
                    end
                    if (height !== e.hgt)
                    begin
                        $display("%0t: height expected %0d actual %0d",
                                 $time, e.hgt, height);
                        errors++;
                    end
                    if (height_valid !== e.hvalid)
                    begin
                        $display("%0t: height_valid expected %0b actual %0b",
                                 $time, e.hvalid, height_valid);
                        errors++;
                    end
                end
                recvd++;
            end
            if (!hold_done && recvd == 400)
            begin
                hold_done <= 1'b1;
                hold_cnt <= 120;
                out_stall <= 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (recvd < 200 || recvd > 350) && ($urandom_range(99) < 29);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        if (idx == REG_NEIGHBORS)
            nbr_reg = val[47:0];
        else
        begin
            vx[idx] = longint'($signed(val[CW-1:0]));
            vy[idx] = longint'($signed(val[2*CW-1:CW]));
            vz[idx] = longint'($signed(val[3*CW-1:2*CW]));
        end
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_triangle(longint ax, longint ay, longint az, longint bx,
                                 longint by, longint bz, longint cx, longint cy,
                                 longint cz, logic [47:0] nbrs);
        // upper four bits carry junk that the 60-bit argument of write_reg cuts off
        write_reg(REG_VERTEX_A, {4'($urandom), az[CW-1:0], ay[CW-1:0], ax[CW-1:0]});
        write_reg(REG_VERTEX_B, {4'($urandom), bz[CW-1:0], by[CW-1:0], bx[CW-1:0]});
        write_reg(REG_VERTEX_C, {4'($urandom), cz[CW-1:0], cy[CW-1:0], cx[CW-1:0]});
        write_reg(REG_NEIGHBORS, {12'($urandom), nbrs});
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !in_valid && hit_q.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic longint rnd_coord(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    task automatic queue_random(int n, int span);
        query_t q;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                q.x = CW'(rnd_coord(span));
                q.z = CW'(rnd_coord(span));
            end
            else
            begin
                q.x = CW'($urandom);
                q.z = CW'($urandom);
            end
            pending_q.push_back(q);
        end
    endtask

    initial
    begin
        int span;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = 0;
            vy[i] = 0;
            vz[i] = 0;
        end
        nbr_reg = '1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset triangle: fully degenerate, every point inside, no height
        pending_q.push_back('{x: CW'(CMAX), z: CW'(CMIN)});
        pending_q.push_back('{x: CW'(0), z: CW'(0)});
        drain();

        // directed: a ccw triangle with on-edge, vertex and far points
        load_triangle(0, 256, 0, 2560, 512, 0, 0, -256, 2560, 48'h0003_0002_0001);
        pending_q.push_back('{x: CW'(0), z: CW'(0)});
        pending_q.push_back('{x: CW'(1280), z: CW'(0)});
        pending_q.push_back('{x: CW'(1280), z: CW'(1280)});
        pending_q.push_back('{x: CW'(0), z: CW'(1280)});
        pending_q.push_back('{x: CW'(500), z: CW'(500)});
        pending_q.push_back('{x: CW'(500), z: CW'(-1)});
        pending_q.push_back('{x: CW'(3000), z: CW'(3000)});
        pending_q.push_back('{x: CW'(-1), z: CW'(500)});
        pending_q.push_back('{x: CW'(CMAX), z: CW'(CMAX)});
        pending_q.push_back('{x: CW'(CMIN), z: CW'(CMIN)});
        pending_q.push_back('{x: CW'(CMIN), z: CW'(CMAX)});
        pending_q.push_back('{x: CW'(CMAX), z: CW'(CMIN)});
        drain();

        // reversed winding
        load_triangle(0, 0, 0, 0, 100, 2560, 2560, -100, 0, 48'h8000_7FFF_FFFF);
        pending_q.push_back('{x: CW'(500), z: CW'(500)});
        pending_q.push_back('{x: CW'(-500), z: CW'(500)});
        pending_q.push_back('{x: CW'(500), z: CW'(-500)});
        pending_q.push_back('{x: CW'(3000), z: CW'(3000)});
        drain();

        // extreme vertices, height saturates
        load_triangle(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX,
                      48'h1234_8000_7FFF);
        queue_random(60, CMAX);
        drain();

        // vertical plane: collinear in xz
        load_triangle(0, 0, 0, 1000, 500, 1000, 2000, -300, 2000, 48'hAAAA_5555_0F0F);
        queue_random(30, 4000);
        drain();

        // zero-length edge ab
        load_triangle(100, 50, 100, 100, 900, 100, 3000, -20, 500, 48'h0000_0001_0002);
        queue_random(30, 4000);
        drain();

        // random triangles with random content
        for (int p = 0; p < 10; p++)
        begin
            span = (p % 3 == 0) ? CMAX : 4096;
            load_triangle(rnd_coord(span), rnd_coord(CMAX), rnd_coord(span),
                          rnd_coord(span), rnd_coord(CMAX), rnd_coord(span),
                          rnd_coord(span), rnd_coord(CMAX), rnd_coord(span),
                          {16'($urandom), 16'($urandom), 16'($urandom)});
            queue_random((p == 2) ? 200 : 40, span + 1000 > CMAX ? CMAX : span + 1000);
            drain();
        end

        if (errors == 0)
            $display("nav_cell_point_test_height: match");
        else
            $display("nav_cell_point_test_height: mismatch");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("nav_cell_point_test_height: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
